// ===== design/lbbp_pkg.sv =====
// Shared types, constants and tables for the lidar beam to body point pipeline.
`timescale 1ns / 1ps

package lbbp_pkg;

    // Field widths
    localparam int ANGLE_W  = 15;
    localparam int RANGE_W  = 16;
    localparam int QUAL_W   = 6;
    localparam int MOUNT_W  = 14;
    localparam int BODY_W   = 13;
    localparam int POINT_W  = 18;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_YAW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_WIDTH  = 3'd7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BODY_HIT  = 2'd2;

    // Angle to binary angle: one turn is ANGLE_STEPS = 2^ANGLE_SHIFT * ANGLE_ODD steps.
    // bin = quotient(a / ANGLE_ODD) in the top bits, table of the remainder below.
    localparam int ANGLE_STEPS = 23040;
    localparam int ANGLE_SHIFT = 9;
    localparam int ANGLE_ODD   = ANGLE_STEPS >> ANGLE_SHIFT;
    localparam int FRAC_BITS   = 32 - ANGLE_SHIFT;
    localparam int ROUND_TERM  = (ANGLE_STEPS / 2) >> ANGLE_SHIFT;
    localparam int REM_W       = 6;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + ANGLE_ODD - 1) / ANGLE_ODD;

    // CORDIC
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_COUNT        = 24;
    localparam int INV_GAIN          = 652032874;
    localparam int GAIN_W            = 30;
    localparam int GAIN_SHIFT        = 14;
    localparam int X0_W              = 32;
    localparam int XW                = 36;
    localparam int TW                = 33;

    // Post processing
    localparam int MOUNT_SHIFT  = 16;
    localparam int ROUND_HALF   = 1 << (MOUNT_SHIFT - 1);
    localparam int SUM_W        = XW + 1;
    localparam int PW           = 21;
    localparam int LIMIT_W      = BODY_W + 1;
    localparam int SELF_MARGIN2 = 120;

    typedef logic [31:0] atan_tab_t [ATAN_COUNT];

    localparam atan_tab_t ATAN_TURN = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef logic [FRAC_BITS-1:0] frac_tab_t [1 << REM_W];

    // Low binary-angle bits for each remainder of the angle by ANGLE_ODD
    function automatic frac_tab_t build_frac_tab();
        frac_tab_t tab;
        longint    num;
        for (int r = 0; r < (1 << REM_W); r++) begin
            if (r < ANGLE_ODD) begin
                num    = (longint'(r) << FRAC_BITS) + longint'(ROUND_TERM);
                tab[r] = FRAC_BITS'(num / ANGLE_ODD);
            end else begin
                tab[r] = '0;
            end
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac_tab();

    typedef struct packed {
        logic [RANGE_W-1:0]        min_range;
        logic [RANGE_W-1:0]        max_range;
        logic signed [MOUNT_W-1:0] mount_x;
        logic signed [MOUNT_W-1:0] mount_y;
        logic [ANGLE_W-1:0]        yaw_red;
        logic                      mirror;
        logic [BODY_W-1:0]         body_length;
        logic [BODY_W-1:0]         body_width;
    } cfg_t;

    // Per-beam flags that ride along the pipeline
    typedef struct packed {
        logic              bad;
        logic              neg;
        logic [QUAL_W-1:0] quality;
    } side_t;

    typedef struct packed {
        logic [QUAL_W-1:0]         quality_out;
        logic signed [POINT_W-1:0] point_y;
        logic signed [POINT_W-1:0] point_x;
        logic [STATUS_W-1:0]       status;
    } item_t;

endpackage

// ===== design/lidar_beam_to_body_point_top.sv =====
// Top level: configuration registers, beam pipeline and output skid buffer.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+---------------------------------------------
//  s_*      | in        | s_tvalid/tready  | beam_angle, beam_range, beam_quality
//  m_*      | out       | m_tvalid/tready  | status, point_x, point_y, quality_out
//  cfg_*    | in        | cfg_valid/ready  | cfg_index, cfg_data (always ready)
//
// One beam per cycle while s_tready is high; the path is 5 front stages + CORDIC_STAGES
// rotation stages + 3 back stages + 1 output register.
// rst_n clears valid bits and loads register defaults; no clearing pass.
// A stalled output fills a one-entry skid register, then s_tready drops and the
// whole pipeline holds on a single enable taken from a register.
`timescale 1ns / 1ps

module lidar_beam_to_body_point_top #(
    parameter int CORDIC_STAGES = lbbp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,   // beam_angle[14:0], beam_range[30:15], beam_quality[36:31], zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // status[1:0], point_x[19:2], point_y[37:20], quality_out[43:38], zero pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lbbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ITEM_W = $bits(lbbp_pkg::item_t);
    localparam logic [lbbp_pkg::ANGLE_W-1:0] STEPS = lbbp_pkg::ANGLE_W'(lbbp_pkg::ANGLE_STEPS);

    localparam lbbp_pkg::cfg_t CFG_RESET = '{
        min_range:   16'd480,
        max_range:   16'd12000,
        mount_x:     14'sd300,
        mount_y:     14'sd160,
        yaw_red:     15'd10368,
        mirror:      1'b1,
        body_length: 13'd1000,
        body_width:  13'd600
    };

    // Configuration registers; yaw is kept reduced to one turn
    lbbp_pkg::cfg_t               cfg_reg;
    lbbp_pkg::cfg_t               cfg_next;
    logic [lbbp_pkg::ANGLE_W-1:0] yaw_raw;

    assign cfg_ready = 1'b1;
    assign yaw_raw   = cfg_data[lbbp_pkg::ANGLE_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lbbp_pkg::CFG_MIN_RANGE:   cfg_next.min_range = cfg_data;
                lbbp_pkg::CFG_MAX_RANGE:   cfg_next.max_range = cfg_data;
                lbbp_pkg::CFG_MOUNT_X:
                    cfg_next.mount_x = signed'(cfg_data[lbbp_pkg::MOUNT_W-1:0]);
                lbbp_pkg::CFG_MOUNT_Y:
                    cfg_next.mount_y = signed'(cfg_data[lbbp_pkg::MOUNT_W-1:0]);
                lbbp_pkg::CFG_MOUNT_YAW:
                    cfg_next.yaw_red = (yaw_raw >= STEPS) ? yaw_raw - STEPS : yaw_raw;
                lbbp_pkg::CFG_MIRROR:      cfg_next.mirror = cfg_data[0];
                lbbp_pkg::CFG_BODY_LENGTH:
                    cfg_next.body_length = cfg_data[lbbp_pkg::BODY_W-1:0];
                lbbp_pkg::CFG_BODY_WIDTH:
                    cfg_next.body_width = cfg_data[lbbp_pkg::BODY_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Pipeline
    logic                           skid_valid_reg;
    logic                           en;

    logic                           ang_valid;
    logic [lbbp_pkg::X0_W-1:0]      ang_x0;
    logic signed [31:0]             ang_t;
    lbbp_pkg::side_t                ang_side;

    logic                           rot_valid;
    logic signed [lbbp_pkg::XW-1:0] rot_x;
    logic signed [lbbp_pkg::XW-1:0] rot_y;
    lbbp_pkg::side_t                rot_side;

    logic                           pipe_valid;
    lbbp_pkg::item_t                pipe_item;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    lbbp_angle u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .beam_angle   (s_tdata[14:0]),
        .beam_range   (s_tdata[30:15]),
        .beam_quality (s_tdata[36:31]),
        .cfg          (cfg_reg),
        .out_valid    (ang_valid),
        .out_x0       (ang_x0),
        .out_t        (ang_t),
        .out_side     (ang_side)
    );

    lbbp_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_valid),
        .in_x0     (ang_x0),
        .in_t      (ang_t),
        .in_side   (ang_side),
        .out_valid (rot_valid),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_side  (rot_side)
    );

    lbbp_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_x      (rot_x),
        .in_y      (rot_y),
        .in_side   (rot_side),
        .cfg       (cfg_reg),
        .out_valid (pipe_valid),
        .out_item  (pipe_item)
    );

    // Output register plus skid entry
    logic            out_valid_reg;
    lbbp_pkg::item_t out_item_reg;
    lbbp_pkg::item_t skid_item_reg;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_valid;
            end
        end
        else if (pipe_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_item_reg <= skid_valid_reg ? skid_item_reg : pipe_item;
        else if (!skid_valid_reg)
            skid_item_reg <= pipe_item;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(48 - ITEM_W)'(0), out_item_reg};

endmodule

// ===== design/lbbp_angle.sv =====
// Front stages: range gate, angle mirror and yaw, binary angle, quadrant fold, gain scaling.
`timescale 1ns / 1ps

module lbbp_angle (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [lbbp_pkg::ANGLE_W-1:0]     beam_angle,
    input  logic [lbbp_pkg::RANGE_W-1:0]     beam_range,
    input  logic [lbbp_pkg::QUAL_W-1:0]      beam_quality,
    input  lbbp_pkg::cfg_t                   cfg,
    output logic                             out_valid,
    output logic [lbbp_pkg::X0_W-1:0]        out_x0,
    output logic signed [31:0]               out_t,
    output lbbp_pkg::side_t                  out_side
);

    localparam logic [lbbp_pkg::ANGLE_W-1:0] STEPS = lbbp_pkg::ANGLE_W'(lbbp_pkg::ANGLE_STEPS);
    localparam int PROD2_W = lbbp_pkg::RANGE_W + lbbp_pkg::GAIN_W;
    localparam int PROD3_W = 2 * lbbp_pkg::ANGLE_W;

    // Stage 1: reduce, mirror, range gate
    logic [lbbp_pkg::ANGLE_W-1:0] a_red;
    logic [lbbp_pkg::ANGLE_W-1:0] a_mir;
    logic                         bad;

    logic                         v1_reg;
    logic [lbbp_pkg::ANGLE_W-1:0] a1_reg;
    logic [lbbp_pkg::RANGE_W-1:0] range1_reg;
    lbbp_pkg::side_t              side1_reg;

    always_comb
    begin
        a_red = (beam_angle >= STEPS) ? beam_angle - STEPS : beam_angle;
        a_mir = (cfg.mirror && a_red != '0) ? STEPS - a_red : a_red;
        bad   = (beam_range < cfg.min_range) || (beam_range > cfg.max_range);
    end

    // Stage 2: add yaw modulo one turn, scale range by inverse CORDIC gain
    logic [lbbp_pkg::ANGLE_W:0]   yaw_sum;
    logic [lbbp_pkg::ANGLE_W-1:0] a_yaw;
    logic [PROD2_W-1:0]           gain_prod;

    logic                         v2_reg;
    logic [lbbp_pkg::ANGLE_W-1:0] a2_reg;
    logic [lbbp_pkg::X0_W-1:0]    x0_2_reg;
    lbbp_pkg::side_t              side2_reg;

    always_comb
    begin
        yaw_sum   = {1'b0, a1_reg} + {1'b0, cfg.yaw_red};
        a_yaw     = (yaw_sum >= {1'b0, STEPS}) ? lbbp_pkg::ANGLE_W'(yaw_sum - {1'b0, STEPS})
                                               : yaw_sum[lbbp_pkg::ANGLE_W-1:0];
        gain_prod = PROD2_W'(range1_reg) * PROD2_W'(lbbp_pkg::INV_GAIN);
    end

    // Stage 3: quotient by the odd factor through a reciprocal multiply
    logic [PROD3_W-1:0]               recip_prod;

    logic                             v3_reg;
    logic [lbbp_pkg::ANGLE_W-1:0]     a3_reg;
    logic [lbbp_pkg::ANGLE_SHIFT-1:0] quo3_reg;
    logic [lbbp_pkg::X0_W-1:0]        x0_3_reg;
    lbbp_pkg::side_t                  side3_reg;

    assign recip_prod = PROD3_W'(a2_reg) * PROD3_W'(lbbp_pkg::RECIP);

    // Stage 4: remainder and binary angle
    logic [lbbp_pkg::ANGLE_W-1:0] quo_mul;
    logic [lbbp_pkg::ANGLE_W-1:0] rem_full;
    logic [lbbp_pkg::REM_W-1:0]   rem_idx;

    logic                         v4_reg;
    logic [31:0]                  bin4_reg;
    logic [lbbp_pkg::X0_W-1:0]    x0_4_reg;
    lbbp_pkg::side_t              side4_reg;

    always_comb
    begin
        quo_mul  = lbbp_pkg::ANGLE_W'(quo3_reg) * lbbp_pkg::ANGLE_W'(lbbp_pkg::ANGLE_ODD);
        rem_full = a3_reg - quo_mul;
        rem_idx  = rem_full[lbbp_pkg::REM_W-1:0];
    end

    // Stage 5: fold outer half turn onto the inner one
    logic signed [31:0] t_bin;
    logic               t_outer;

    logic               v5_reg;
    logic signed [31:0] t5_reg;
    logic [lbbp_pkg::X0_W-1:0] x0_5_reg;
    lbbp_pkg::side_t    side5_reg;

    always_comb
    begin
        t_bin   = signed'(bin4_reg);
        t_outer = (t_bin > 32'sd1073741824) || (t_bin < -32'sd1073741824);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg            <= a_mir;
            range1_reg        <= beam_range;
            side1_reg.bad     <= bad;
            side1_reg.neg     <= 1'b0;
            side1_reg.quality <= beam_quality;

            a2_reg    <= a_yaw;
            x0_2_reg  <= gain_prod[lbbp_pkg::GAIN_SHIFT +: lbbp_pkg::X0_W];
            side2_reg <= side1_reg;

            a3_reg    <= a2_reg;
            quo3_reg  <= recip_prod[lbbp_pkg::RECIP_SHIFT +: lbbp_pkg::ANGLE_SHIFT];
            x0_3_reg  <= x0_2_reg;
            side3_reg <= side2_reg;

            bin4_reg  <= {quo3_reg, lbbp_pkg::FRAC_TAB[rem_idx]};
            x0_4_reg  <= x0_3_reg;
            side4_reg <= side3_reg;

            // Subtracting or adding half a turn both amount to flipping the sign bit
            t5_reg            <= t_outer ? {~t_bin[31], t_bin[30:0]} : t_bin;
            x0_5_reg          <= x0_4_reg;
            side5_reg.bad     <= side4_reg.bad;
            side5_reg.neg     <= t_outer;
            side5_reg.quality <= side4_reg.quality;
        end
    end

    assign out_valid = v5_reg;
    assign out_x0    = x0_5_reg;
    assign out_t     = t5_reg;
    assign out_side  = side5_reg;

endmodule

// ===== design/lbbp_cordic.sv =====
// Rotation-mode CORDIC, one registered micro-rotation per stage.
`timescale 1ns / 1ps

module lbbp_cordic #(
    parameter int STAGES = lbbp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [lbbp_pkg::X0_W-1:0]       in_x0,
    input  logic signed [31:0]              in_t,
    input  lbbp_pkg::side_t                 in_side,
    output logic                            out_valid,
    output logic signed [lbbp_pkg::XW-1:0]  out_x,
    output logic signed [lbbp_pkg::XW-1:0]  out_y,
    output lbbp_pkg::side_t                 out_side
);

    logic                           valid_reg [STAGES];
    logic signed [lbbp_pkg::XW-1:0] x_reg     [STAGES];
    logic signed [lbbp_pkg::XW-1:0] y_reg     [STAGES];
    logic signed [lbbp_pkg::TW-1:0] t_reg     [STAGES];
    lbbp_pkg::side_t                side_reg  [STAGES];

    genvar g;
    for (g = 0; g < STAGES; g++)
    begin : g_stage
        logic                           v_in;
        logic signed [lbbp_pkg::XW-1:0] x_in;
        logic signed [lbbp_pkg::XW-1:0] y_in;
        logic signed [lbbp_pkg::TW-1:0] t_in;
        lbbp_pkg::side_t                s_in;
        logic signed [lbbp_pkg::XW-1:0] dx;
        logic signed [lbbp_pkg::XW-1:0] dy;
        logic signed [lbbp_pkg::TW-1:0] ang;

        if (g == 0)
        begin : g_first
            assign v_in = in_valid;
            assign x_in = signed'(lbbp_pkg::XW'(in_x0));
            assign y_in = '0;
            assign t_in = lbbp_pkg::TW'(in_t);
            assign s_in = in_side;
        end
        else
        begin : g_next
            assign v_in = valid_reg[g-1];
            assign x_in = x_reg[g-1];
            assign y_in = y_reg[g-1];
            assign t_in = t_reg[g-1];
            assign s_in = side_reg[g-1];
        end

        // Arithmetic shift rounds toward minus infinity
        assign dx  = y_in >>> g;
        assign dy  = x_in >>> g;
        assign ang = signed'(lbbp_pkg::TW'(lbbp_pkg::ATAN_TURN[g]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= s_in;
                if (t_in >= 0)
                begin
                    x_reg[g] <= x_in - dx;
                    y_reg[g] <= y_in + dy;
                    t_reg[g] <= t_in - ang;
                end
                else
                begin
                    x_reg[g] <= x_in + dx;
                    y_reg[g] <= y_in - dy;
                    t_reg[g] <= t_in + ang;
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_y     = y_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== design/lbbp_post.sv =====
// Back stages: quadrant sign, mount offset with rounding, self-hit box and status.
`timescale 1ns / 1ps

module lbbp_post (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [lbbp_pkg::XW-1:0]  in_x,
    input  logic signed [lbbp_pkg::XW-1:0]  in_y,
    input  lbbp_pkg::side_t                 in_side,
    input  lbbp_pkg::cfg_t                  cfg,
    output logic                            out_valid,
    output lbbp_pkg::item_t                 out_item
);

    localparam int SW = lbbp_pkg::SUM_W;
    localparam int PW = lbbp_pkg::PW;
    localparam int LW = lbbp_pkg::LIMIT_W;
    localparam int CW = PW + 1;

    // Stage 1: undo the half-turn fold
    logic                           v1_reg;
    logic signed [lbbp_pkg::XW-1:0] x1_reg;
    logic signed [lbbp_pkg::XW-1:0] y1_reg;
    lbbp_pkg::side_t                side1_reg;

    // Stage 2: add mount offset and round to nearest, halves up
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] shr_x;
    logic signed [SW-1:0] shr_y;

    logic                 v2_reg;
    logic signed [PW-1:0] px2_reg;
    logic signed [PW-1:0] py2_reg;
    lbbp_pkg::side_t      side2_reg;

    always_comb
    begin
        sum_x = SW'(x1_reg) + (SW'(cfg.mount_x) <<< lbbp_pkg::MOUNT_SHIFT)
              + SW'(lbbp_pkg::ROUND_HALF);
        sum_y = SW'(y1_reg) + (SW'(cfg.mount_y) <<< lbbp_pkg::MOUNT_SHIFT)
              + SW'(lbbp_pkg::ROUND_HALF);
        shr_x = sum_x >>> lbbp_pkg::MOUNT_SHIFT;
        shr_y = sum_y >>> lbbp_pkg::MOUNT_SHIFT;
    end

    // Stage 3: body box test and result assembly
    logic [PW-1:0] abs_x;
    logic [PW-1:0] abs_y;
    logic [LW-1:0] lim_x;
    logic [LW-1:0] lim_y;
    logic          in_box;
    lbbp_pkg::item_t item;

    logic            v3_reg;
    lbbp_pkg::item_t item3_reg;

    always_comb
    begin
        abs_x  = (px2_reg < 0) ? PW'(-px2_reg) : PW'(px2_reg);
        abs_y  = (py2_reg < 0) ? PW'(-py2_reg) : PW'(py2_reg);
        lim_x  = LW'(cfg.body_length) + LW'(lbbp_pkg::SELF_MARGIN2);
        lim_y  = LW'(cfg.body_width) + LW'(lbbp_pkg::SELF_MARGIN2);
        in_box = ({abs_x, 1'b0} <= CW'(lim_x)) && ({abs_y, 1'b0} <= CW'(lim_y));

        item.quality_out = side2_reg.quality;
        if (side2_reg.bad)
        begin
            item.status  = lbbp_pkg::ST_BAD_RANGE;
            item.point_x = '0;
            item.point_y = '0;
        end
        else
        begin
            item.status  = in_box ? lbbp_pkg::ST_BODY_HIT : lbbp_pkg::ST_OK;
            item.point_x = px2_reg[lbbp_pkg::POINT_W-1:0];
            item.point_y = py2_reg[lbbp_pkg::POINT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= in_side.neg ? -in_x : in_x;
            y1_reg    <= in_side.neg ? -in_y : in_y;
            side1_reg <= in_side;

            px2_reg   <= shr_x[PW-1:0];
            py2_reg   <= shr_y[PW-1:0];
            side2_reg <= side1_reg;

            item3_reg <= item;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

// ===== test/lidar_beam_to_body_point_top_test.sv =====
// Self-checking testbench for the beam to body point pipeline, with a built-in point predictor.
`timescale 1ns / 1ps

module lidar_beam_to_body_point_top_test;

    import lbbp_pkg::*;

    localparam longint TURN_STEPS = 23040;
    localparam longint TURN32     = 64'sd4294967296;
    localparam longint HALF32     = 64'sd2147483648;
    localparam longint QUARTER32  = 64'sd1073741824;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint BOX_MARGIN = 120;
    localparam int     ROT_STAGES = 16;
    localparam int     BEAMS_PER_PHASE = 215;
    localparam int     PHASES     = 7;

    localparam longint ARCTAN [ROT_STAGES] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10680862,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861
    };

    typedef struct packed {
        logic [ANGLE_W-1:0]        ang;
        logic [RANGE_W-1:0]        rng;
        logic [QUAL_W-1:0]         qual;
        logic                      typed;
        logic [STATUS_W-1:0]       st;
        logic signed [POINT_W-1:0] px;
        logic signed [POINT_W-1:0] py;
    } beam_row_t;

    localparam int PROBE_COUNT = 20;

    // Rows with typed results are range rejects; the rest go through the predictor.
    localparam beam_row_t PROBES [PROBE_COUNT] = '{
        '{15'd0,     16'd0,     6'd0,  1'b1, ST_BAD_RANGE, 18'sd0, 18'sd0},
        '{15'd23039, 16'd65535, 6'd63, 1'b1, ST_BAD_RANGE, 18'sd0, 18'sd0},
        '{15'd32767, 16'd479,   6'd42, 1'b1, ST_BAD_RANGE, 18'sd0, 18'sd0},
        '{15'd100,   16'd12001, 6'd1,  1'b1, ST_BAD_RANGE, 18'sd0, 18'sd0},
        '{15'd0,     16'd480,   6'd5,  1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd0,     16'd12000, 6'd6,  1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd1,     16'd12000, 6'd63, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd5760,  16'd4000,  6'd0,  1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd11520, 16'd4000,  6'd8,  1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd17280, 16'd4000,  6'd9,  1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd23039, 16'd4000,  6'd10, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd23040, 16'd4000,  6'd11, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd32767, 16'd4000,  6'd12, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd10368, 16'd8000,  6'd13, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd4608,  16'd8000,  6'd14, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd16128, 16'd8000,  6'd15, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd21888, 16'd480,   6'd16, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd21888, 16'd600,   6'd17, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd16384, 16'd9999,  6'd21, 1'b0, ST_OK,        18'sd0, 18'sd0},
        '{15'd8191,  16'd7777,  6'd48, 1'b0, ST_OK,        18'sd0, 18'sd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // beam_angle, beam_range, beam_quality, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // status, point_x, point_y, quality_out, zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register shadow, reset values
    logic [RANGE_W-1:0]        min_rng  = 16'd480;
    logic [RANGE_W-1:0]        max_rng  = 16'd12000;
    logic signed [MOUNT_W-1:0] mnt_x    = 14'sd300;
    logic signed [MOUNT_W-1:0] mnt_y    = 14'sd160;
    logic [ANGLE_W-1:0]        mnt_yaw  = 15'd10368;
    logic                      mir      = 1'b1;
    logic [BODY_W-1:0]         body_len = 13'd1000;
    logic [BODY_W-1:0]         body_wid = 13'd600;

    item_t pending_points [$];
    int    mismatches = 0;
    int    rx_left = 0;
    bit    rx_val = 1'b0;

    lidar_beam_to_body_point_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    function automatic item_t body_point(input logic [ANGLE_W-1:0] ang,
                                         input logic [RANGE_W-1:0] rng,
                                         input logic [QUAL_W-1:0] qual);
        item_t  res;
        longint a, t, x, y, dx, dy, px, py, ox, oy, bx, by;
        bit     flip;
        res = '0;
        flip = 1'b0;
        res.quality_out = qual;
        if (rng < min_rng || rng > max_rng)
        begin
            res.status = ST_BAD_RANGE;
            return res;
        end
        a = ang;
        a = a % TURN_STEPS;
        if (mir && a != 0)
            a = TURN_STEPS - a;
        t = mnt_yaw;
        a = (a + t % TURN_STEPS) % TURN_STEPS;
        // binary angle, 2^32 per turn, rounded to nearest
        t = ((a << 32) + TURN_STEPS / 2) / TURN_STEPS;
        if (t >= HALF32)
            t -= TURN32;
        // fold into the right half plane, negate the vector afterwards
        if (t > QUARTER32)
        begin
            t -= HALF32;
            flip = 1'b1;
        end
        else if (t < -QUARTER32)
        begin
            t += HALF32;
            flip = 1'b1;
        end
        x = rng;
        x = (x * GAIN_Q30) >>> 14;
        y = 0;
        for (int i = 0; i < ROT_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0)
            begin
                x -= dx;
                y += dy;
                t -= ARCTAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                t += ARCTAN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        ox = mnt_x;
        oy = mnt_y;
        px = (x + ox * 65536 + 32768) >>> 16;
        py = (y + oy * 65536 + 32768) >>> 16;
        bx = body_len;
        by = body_wid;
        if ((px < 0 ? -px : px) * 2 <= bx + BOX_MARGIN &&
            (py < 0 ? -py : py) * 2 <= by + BOX_MARGIN)
            res.status = ST_BODY_HIT;
        else
            res.status = ST_OK;
        res.point_x = px[POINT_W-1:0];
        res.point_y = py[POINT_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3000));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return min_rng - 16'd1;
                    1: return min_rng;
                    2: return max_rng;
                    default: return max_rng + 16'd1;
                endcase
            end
            default: return 16'($urandom_range(min_rng, max_rng));
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN_RANGE:   min_rng  = val;
            CFG_MAX_RANGE:   max_rng  = val;
            CFG_MOUNT_X:     mnt_x    = val[MOUNT_W-1:0];
            CFG_MOUNT_Y:     mnt_y    = val[MOUNT_W-1:0];
            CFG_MOUNT_YAW:   mnt_yaw  = val[ANGLE_W-1:0];
            CFG_MIRROR:      mir      = val[0];
            CFG_BODY_LENGTH: body_len = val[BODY_W-1:0];
            CFG_BODY_WIDTH:  body_wid = val[BODY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] mx, input logic [15:0] my,
                              input logic [15:0] yaw, input logic [15:0] flip,
                              input logic [15:0] blen, input logic [15:0] bwid);
        cfg_write(CFG_MIN_RANGE, lo);
        cfg_write(CFG_MAX_RANGE, hi);
        cfg_write(CFG_MOUNT_X, mx);
        cfg_write(CFG_MOUNT_Y, my);
        cfg_write(CFG_MOUNT_YAW, yaw);
        cfg_write(CFG_MIRROR, flip);
        cfg_write(CFG_BODY_LENGTH, blen);
        cfg_write(CFG_BODY_WIDTH, bwid);
        cfg_valid <= 1'b0;
    endtask

    // Present one beam and hold it until accepted; queue what it should produce
    task automatic send_beam(input logic [ANGLE_W-1:0] ang, input logic [RANGE_W-1:0] rng,
                             input logic [QUAL_W-1:0] qual, input bit typed,
                             input item_t want);
        s_tdata  <= {3'b000, qual, rng, ang};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (typed)
            pending_points.insert(pending_points.size(), want);
        else
            pending_points.insert(pending_points.size(), body_point(ang, rng, qual));
    endtask

    task automatic drain();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        int    burst;
        int    gap;
        item_t want;
        logic [ANGLE_W-1:0] ang;
        burst = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                1: set_config(16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0,
                              16'd8191, 16'd8191);
                // inverted window: everything rejected
                2: set_config(16'd65535, 16'd0, 16'(-8192), 16'd8191, 16'd23039, 16'd1,
                              16'd0, 16'd0);
                3: set_config(16'd1000, 16'd1000, 16'd8191, 16'(-8192), 16'd32767,
                              16'hFFFE, 16'd0, 16'd0);
                4: set_config(16'd0, 16'd65535, 16'hFFFF, 16'hFFFF, 16'd11520, 16'd1,
                              16'd0, 16'd0);
                5: set_config(16'($urandom_range(0, 3000)), 16'($urandom_range(3000, 65535)),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)));
                6: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default: ;
            endcase
            if (ph == 0)
            begin
                for (int k = 0; k < PROBE_COUNT; k++)
                begin
                    want.status      = PROBES[k].st;
                    want.point_x     = PROBES[k].px;
                    want.point_y     = PROBES[k].py;
                    want.quality_out = PROBES[k].qual;
                    send_beam(PROBES[k].ang, PROBES[k].rng, PROBES[k].qual,
                              PROBES[k].typed, want);
                    if (k % 5 == 4)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (idle_len()) @(posedge clk);
                    end
                end
            end
            for (int n = 0; n < BEAMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    ang = 15'($urandom_range(23040, 32767));
                else
                    ang = 15'($urandom_range(0, 23039));
                send_beam(ang, pick_range(), 6'($urandom_range(0, 63)), 1'b0, '0);
                gap = 0;
                if (burst > 0)
                    burst--;
                else if ($urandom_range(0, 99) < 15)
                    burst = $urandom_range(20, 60);
                else if ($urandom_range(0, 99) < 45)
                    gap = idle_len();
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            s_tvalid <= 1'b0;
        end
        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output stalls: short and long gaps, with no-stall stretches between
    always @(posedge clk)
    begin
        int r;
        if (rx_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                rx_val  = 1'b1;
                rx_left = $urandom_range(20, 80);
            end
            else if (r < 35)
            begin
                rx_val  = 1'b0;
                rx_left = idle_len();
            end
            else
            begin
                rx_val  = 1'b1;
                rx_left = 1;
            end
        end
        rx_left--;
        m_tready <= rx_val;
    end

    always @(posedge clk)
    begin
        item_t got;
        item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[43:0];
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unrequested result: status %0d x %0d y %0d quality %0d",
                             got.status, got.point_x, got.point_y, got.quality_out);
            end
            else
            begin
                want = pending_points.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch (expected/actual): status %0d/%0d ",
                                  "x %0d/%0d y %0d/%0d quality %0d/%0d"},
                                 want.status, got.status, want.point_x, got.point_x,
                                 want.point_y, got.point_y,
                                 want.quality_out, got.quality_out);
                end
            end
        end
    end

endmodule
